[hdl/door_open_request_tracker_top_macros.svh]
// Assertion macros for the door open request tracker checker.
// Used by dort_checker.sv; depends on a clock named clk and a reset named rst.
`ifndef DOOR_OPEN_REQUEST_TRACKER_TOP_MACROS_SVH
`define DOOR_OPEN_REQUEST_TRACKER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DORT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("door tracker check failed");

// Consequent must hold in the cycle after the antecedent.
`define DORT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("door tracker check failed");

`endif

[hdl/dort_pkg.sv]
// Shared types and constants of the door open request tracker.
// No dependencies; dort_if.sv, dort_front, dort_back and the top level import it.
package dort_pkg;

  localparam int CMD_W   = 2;
  localparam int DOOR_W  = 4;
  localparam int REQ_W   = 4;
  localparam int STAMP_W = 63;
  localparam int MODE_W  = 2;

  localparam int DOOR_SPAN = 1 << DOOR_W;
  localparam int REQ_SPAN  = 1 << REQ_W;

  // Input command codes.
  localparam logic [CMD_W-1:0] CMD_OPEN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

  // Reported door modes.
  localparam logic [MODE_W-1:0] DMODE_OPEN   = 2'd0;
  localparam logic [MODE_W-1:0] DMODE_CLOSED = 2'd1;
  localparam logic [MODE_W-1:0] DMODE_MOVING = 2'd2;

  // Commanded door modes.
  localparam logic TMODE_OPEN   = 1'b0;
  localparam logic TMODE_CLOSED = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_OPEN,
    OP_CLOSE,
    OP_REPORT
  } dort_op_t;

  typedef struct packed {
    dort_op_t             op;
    logic [DOOR_W-1:0]    door;
    logic [REQ_W-1:0]     requester;
    logic [STAMP_W-1:0]   stamp;
    logic [MODE_W-1:0]    door_mode;
  } dort_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } dort_state_t;

endpackage

[hdl/dort_if.sv]
// Valid/ready channel interfaces of the door open request tracker.
// Depends on dort_pkg for the field widths.
interface dort_req_if;
  import dort_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [DOOR_W-1:0]    door;
  logic [REQ_W-1:0]     requester;
  logic [STAMP_W-1:0]   stamp;
  logic [MODE_W-1:0]    door_mode;

  modport source (output valid, command, door, requester, stamp, door_mode, input ready);
  modport sink (input valid, command, door, requester, stamp, door_mode, output ready);
endinterface

interface dort_cmd_if;
  import dort_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DOOR_W-1:0]    target_door;
  logic                 target_mode;

  modport source (output valid, target_door, target_mode, input ready);
  modport sink (input valid, target_door, target_mode, output ready);
endinterface

[hdl/dort_front.sv]
// Front end: accepts requests, classifies them and queues the useful ones.
// Depends on dort_pkg and dort_req_if.
module dort_front #(
  parameter int DOOR_COUNT      = 16,
  parameter int REQUESTER_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst,
  dort_req_if.sink            req,
  output logic                q_valid,
  output dort_pkg::dort_item_t q_item,
  input  logic                q_take
);
  import dort_pkg::*;

  dort_item_t entries [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  dort_item_t item_in;
  logic       door_ok;
  logic       req_ok;
  logic       keep;
  logic       push;

  // Items that can have no effect are taken and dropped here.
  always_comb begin
    door_ok = int'(req.door) < DOOR_COUNT;
    req_ok  = int'(req.requester) < REQUESTER_COUNT;
    item_in.door      = req.door;
    item_in.requester = req.requester;
    item_in.stamp     = req.stamp;
    item_in.door_mode = req.door_mode;
    case (req.command)
      CMD_OPEN: begin
        item_in.op = OP_OPEN;
        keep       = door_ok && req_ok;
      end
      CMD_CLOSE: begin
        item_in.op = OP_CLOSE;
        keep       = door_ok && req_ok;
      end
      CMD_REPORT: begin
        item_in.op = OP_REPORT;
        keep       = door_ok;
      end
      default: begin
        item_in.op = OP_REPORT;
        keep       = 1'b0;
      end
    endcase
  end

  assign req.ready = (count != 2'(QUEUE_DEPTH));
  assign push      = req.valid && req.ready && keep;
  assign q_valid   = (count != 2'd0);
  assign q_item    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_take);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

endmodule

[hdl/dort_back.sv]
// Back end: applies queued items to the pending marks and stamp memory.
// Depends on dort_pkg and dort_cmd_if.
module dort_back #(
  parameter int DOOR_COUNT      = 16,
  parameter int REQUESTER_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  dort_pkg::dort_item_t q_item,
  output logic                 q_take,
  dort_cmd_if.source           cmd
);
  import dort_pkg::*;

  localparam int ROWS   = (DOOR_COUNT < DOOR_SPAN) ? DOOR_COUNT : DOOR_SPAN;
  localparam int COLS   = (REQUESTER_COUNT < REQ_SPAN) ? REQUESTER_COUNT : REQ_SPAN;
  localparam int DEPTH  = ROWS * COLS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dort_state_t state;
  dort_state_t state_next;

  logic [COLS-1:0]    marks [ROWS];
  logic [STAMP_W-1:0] stamps [DEPTH];
  logic [STAMP_W-1:0] rd_stamp;
  dort_item_t         cur;

  logic                out_valid;
  logic [DOOR_W-1:0]   out_door;
  logic                out_mode;
  logic                out_free;

  logic [SLOT_W-1:0] take_slot;
  logic [SLOT_W-1:0] cur_slot;
  logic [ROW_W-1:0]  row_idx;
  logic [COL_W-1:0]  col_idx;
  logic [COLS-1:0]   row;
  logic [COLS-1:0]   row_cleared;
  logic              mark;
  logic              commit;
  logic              wr_en;
  logic              set_mark;
  logic              clr_mark;
  logic              emit;
  logic              emit_mode;

  assign take_slot = SLOT_W'(q_item.door[ROW_W-1:0]) * SLOT_W'(COLS)
                   + SLOT_W'(q_item.requester[COL_W-1:0]);
  assign row_idx   = cur.door[ROW_W-1:0];
  assign col_idx   = cur.requester[COL_W-1:0];
  assign cur_slot  = SLOT_W'(row_idx) * SLOT_W'(COLS) + SLOT_W'(col_idx);
  assign row       = marks[row_idx];
  assign mark      = row[col_idx];
  assign row_cleared = row & ~(COLS'(1) << col_idx);
  assign out_free  = !out_valid || cmd.ready;

  // Decision for the item held in cur, using the stamp read on take.
  always_comb begin
    wr_en     = 1'b0;
    set_mark  = 1'b0;
    clr_mark  = 1'b0;
    emit      = 1'b0;
    emit_mode = TMODE_OPEN;
    case (cur.op)
      OP_OPEN: begin
        wr_en     = !mark || (cur.stamp > rd_stamp);
        set_mark  = 1'b1;
        emit      = 1'b1;
        emit_mode = TMODE_OPEN;
      end
      OP_CLOSE: begin
        if (mark && !(cur.stamp < rd_stamp)) begin
          clr_mark  = 1'b1;
          emit      = (row_cleared == '0);
          emit_mode = TMODE_CLOSED;
        end
      end
      OP_REPORT: begin
        if (row == '0) begin
          emit      = (cur.door_mode == DMODE_OPEN) || (cur.door_mode == DMODE_MOVING);
          emit_mode = TMODE_CLOSED;
        end else begin
          emit      = (cur.door_mode == DMODE_CLOSED) || (cur.door_mode == DMODE_MOVING);
          emit_mode = TMODE_OPEN;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_take     = 1'b0;
    commit     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_take     = 1'b1;
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      cur      <= q_item;
      rd_stamp <= stamps[take_slot];
    end
    if (commit && wr_en) begin
      stamps[cur_slot] <= cur.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        marks[r] <= '0;
      end
    end else if (commit) begin
      if (set_mark) begin
        marks[row_idx] <= row | (COLS'(1) << col_idx);
      end else if (clr_mark) begin
        marks[row_idx] <= row_cleared;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && emit) begin
      out_valid <= 1'b1;
    end else if (cmd.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && emit) begin
      out_door <= cur.door;
      out_mode <= emit_mode;
    end
  end

  assign cmd.valid       = out_valid;
  assign cmd.target_door = out_door;
  assign cmd.target_mode = out_mode;

endmodule

[hdl/door_open_request_tracker_top.sv]
// Top level of the door open request tracker: front end, queue and back end.
// Depends on dort_pkg, dort_if.sv, dort_front and dort_back.
//
//   channel | direction | carries
//   --------+-----------+---------------------------------------------------
//   req     | in        | command, door, requester, stamp, door_mode
//   cmd     | out       | target_door, target_mode (zero or one per request)
//
// Each queued request passes through two back-end states: ST_IDLE takes it from
// the queue and reads its stamp entry, ST_APPLY compares, writes back and
// updates the marks. That stamp memory read-modify-write sets the rate.
// Reset is synchronous; it clears all pending marks and empties the queue.
// The stamp memory is not cleared, since an entry's value is used only under its mark.
// A stalled cmd transfer holds the back end, and the two-entry queue then fills.
module door_open_request_tracker_top #(
  parameter int DOOR_COUNT      = 16,
  parameter int REQUESTER_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst,
  dort_req_if.sink   req,
  dort_cmd_if.source cmd
);
  import dort_pkg::*;

  // Classified request passed from the front queue to the back end.
  logic       q_valid;
  dort_item_t q_item;
  logic       q_take;

  // The front end accepts every transfer while its queue has room. Requests that
  // cannot change state or produce a command (unknown command, door out of range,
  // requester out of range on open/close) are dropped and never reach the back end.
  dort_front #(
    .DOOR_COUNT      (DOOR_COUNT),
    .REQUESTER_COUNT (REQUESTER_COUNT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  // The back end owns the per-door mark rows and the per-slot stamp memory.
  // Its output register lets a finished command wait while the next item is
  // looked up.
  dort_back #(
    .DOOR_COUNT      (DOOR_COUNT),
    .REQUESTER_COUNT (REQUESTER_COUNT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take),
    .cmd     (cmd)
  );

endmodule

[hdl/dort_checker.sv]
// Port-level checks for the door open request tracker, bound to the top level.
// Depends on door_open_request_tracker_top_macros.svh.
`include "door_open_request_tracker_top_macros.svh"

module dort_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic [3:0] cmd_target_door,
  input logic       cmd_target_mode
);

  // Reset leaves no command pending.
  `DORT_ASSERT_NOW(a_no_cmd_after_reset, $past(rst), !cmd_valid)

  // Reset empties the queue, so requests are taken right away.
  `DORT_ASSERT_NOW(a_ready_after_reset, $past(rst), req_ready)

  // A command that is not taken stays and keeps its contents.
  `DORT_ASSERT_NEXT(a_cmd_holds, cmd_valid && !cmd_ready,
    cmd_valid && $stable(cmd_target_door) && $stable(cmd_target_mode))

endmodule

bind door_open_request_tracker_top dort_checker u_dort_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .cmd_target_door (cmd.target_door),
  .cmd_target_mode (cmd.target_mode)
);
